/* rtl/core/lpbe_pkg.sv */
`default_nettype none

package lpbe_pkg;

    // Per-item control bits that ride along the pipeline with the data.
    typedef struct packed {
        logic x_major;   // x is the major axis
        logic min_neg;   // minor coordinate decreases along the line
        logic last;      // step equals the major-axis length
        logic beyond;    // step exceeds the major-axis length
        logic len_zero;  // both endpoints coincide
    } lpbe_flags_t;

endpackage

`default_nettype wire

/* rtl/core/lpbe_line_if.sv */
`default_nettype none

interface lpbe_line_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] step_index;

    modport source (
        output valid,
        output start_x,
        output start_y,
        output end_x,
        output end_y,
        output step_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_x,
        input  start_y,
        input  end_x,
        input  end_y,
        input  step_index,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/lpbe_pixel_if.sv */
`default_nettype none

interface lpbe_pixel_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
    logic                  beyond_end;

    modport source (
        output valid,
        output pixel_x,
        output pixel_y,
        output last_pixel,
        output beyond_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  pixel_x,
        input  pixel_y,
        input  last_pixel,
        input  beyond_end,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/line_point_by_equation.sv */
// Line point by equation: returns one pixel of a straight line per request.
//
// Channel "line" (valid/ready) carries both endpoints and a step index along
// the major axis; channel "pixel" (valid/ready) returns the pixel at that
// step, a flag for the end point and a flag for steps past the end (then the
// coordinates read zero). Every request transfer yields exactly one pixel
// transfer, in order.
//
// The pipeline has COORD_BITS+3 register stages: endpoint decode, one
// multiply, COORD_BITS restoring-division stages (one quotient bit each) and
// the output register. A new request is taken in every cycle unless every
// stage is full while the receiver stalls, so throughput is one pixel per
// clock while the receiver is ready.
//
// Each stage holds its own valid bit. When the receiver stalls, the output
// register holds and stages behind it keep moving until they close up on a
// full stage; ready drops only once every stage is full. Nothing is lost or
// repeated. Reset clears all valid bits; the pipeline is empty afterwards.
`default_nettype none

module line_point_by_equation #(
    parameter int COORD_BITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    lpbe_line_if.sink    line,
    lpbe_pixel_if.source pixel
);

    localparam int N      = COORD_BITS;
    localparam int W      = 2 * N + 1;   // dividend width: 2*s*dmin + len
    localparam int NST    = N + 3;       // decode, multiply, N divide, output
    localparam int OUT_ST = N + 2;

    // ------------------------------------------------------------------
    // Valid bits and stage advance
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] take;

    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            // A stage loads when it or some stage ahead of it has room.
            take[i] = pixel.ready | (|((~vld_reg) >> i));
        end
        vld_next[0] = take[0] ? line.valid : vld_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            vld_next[i] = take[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign line.ready = take[0];

    // ------------------------------------------------------------------
    // Stage A: endpoint decode
    // ------------------------------------------------------------------
    logic         dx_neg, dy_neg;
    logic [N-1:0] adx, ady;
    logic         a_x_major_next;

    logic         a_x_major_reg;
    logic         a_maj_neg_reg;
    logic         a_min_neg_reg;
    logic [N-1:0] a_len_reg;
    logic [N-1:0] a_dmin_reg;
    logic [N-1:0] a_maj_start_reg;
    logic [N-1:0] a_min_start_reg;
    logic [N-1:0] a_step_reg;

    always_comb
    begin
        dx_neg         = line.end_x < line.start_x;
        dy_neg         = line.end_y < line.start_y;
        adx            = dx_neg ? line.start_x - line.end_x : line.end_x - line.start_x;
        ady            = dy_neg ? line.start_y - line.end_y : line.end_y - line.start_y;
        a_x_major_next = ady <= adx;   // exact diagonal goes to x
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            a_x_major_reg   <= a_x_major_next;
            a_maj_neg_reg   <= a_x_major_next ? dx_neg : dy_neg;
            a_min_neg_reg   <= a_x_major_next ? dy_neg : dx_neg;
            a_len_reg       <= a_x_major_next ? adx : ady;
            a_dmin_reg      <= a_x_major_next ? ady : adx;
            a_maj_start_reg <= a_x_major_next ? line.start_x : line.start_y;
            a_min_start_reg <= a_x_major_next ? line.start_y : line.start_x;
            a_step_reg      <= line.step_index;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: step * dminor, major coordinate, end tests
    // ------------------------------------------------------------------
    logic [2*N-1:0]          b_prod_reg;
    logic [N-1:0]            b_len_reg;
    logic [N-1:0]            b_maj_reg;
    logic [N-1:0]            b_min_start_reg;
    lpbe_pkg::lpbe_flags_t   b_flags_reg;

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            b_prod_reg           <= (2*N)'(a_step_reg) * (2*N)'(a_dmin_reg);
            b_len_reg            <= a_len_reg;
            b_maj_reg            <= a_maj_neg_reg ? a_maj_start_reg - a_step_reg
                                                  : a_maj_start_reg + a_step_reg;
            b_min_start_reg      <= a_min_start_reg;
            b_flags_reg.x_major  <= a_x_major_reg;
            b_flags_reg.min_neg  <= a_min_neg_reg;
            b_flags_reg.last     <= a_step_reg == a_len_reg;
            b_flags_reg.beyond   <= a_step_reg > a_len_reg;
            b_flags_reg.len_zero <= a_len_reg == '0;
        end
    end

    // ------------------------------------------------------------------
    // Divide stages: (2*s*dmin + len) / (2*len), one quotient bit each,
    // most significant first. The quotient never exceeds the step, so N bits.
    // ------------------------------------------------------------------
    logic [W-1:0]          d_rem_reg       [N];
    logic [N-1:0]          d_quo_reg       [N];
    logic [N-1:0]          d_len_reg       [N];
    logic [N-1:0]          d_maj_reg       [N];
    logic [N-1:0]          d_min_start_reg [N];
    lpbe_pkg::lpbe_flags_t d_flags_reg     [N];

    for (genvar k = 0; k < N; k++)
    begin : g_div
        localparam int SH = N - k;   // 2*len shifted to quotient bit N-1-k

        logic [W-1:0]          rem_in;
        logic [N-1:0]          quo_in;
        logic [N-1:0]          len_in;
        logic [N-1:0]          maj_in;
        logic [N-1:0]          min_start_in;
        lpbe_pkg::lpbe_flags_t flags_in;
        logic [W-1:0]          trial;
        logic                  fits;

        if (k == 0)
        begin : g_first
            assign rem_in       = {b_prod_reg, 1'b0} + W'(b_len_reg);
            assign quo_in       = '0;
            assign len_in       = b_len_reg;
            assign maj_in       = b_maj_reg;
            assign min_start_in = b_min_start_reg;
            assign flags_in     = b_flags_reg;
        end
        else
        begin : g_next
            assign rem_in       = d_rem_reg[k-1];
            assign quo_in       = d_quo_reg[k-1];
            assign len_in       = d_len_reg[k-1];
            assign maj_in       = d_maj_reg[k-1];
            assign min_start_in = d_min_start_reg[k-1];
            assign flags_in     = d_flags_reg[k-1];
        end

        assign trial = W'(len_in) << SH;
        assign fits  = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (take[k+2])
            begin
                d_rem_reg[k]       <= fits ? rem_in - trial : rem_in;
                d_quo_reg[k]       <= quo_in | (N'(fits) << (SH - 1));
                d_len_reg[k]       <= len_in;
                d_maj_reg[k]       <= maj_in;
                d_min_start_reg[k] <= min_start_in;
                d_flags_reg[k]     <= flags_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply minor sign, map axes, blank past the end
    // ------------------------------------------------------------------
    lpbe_pkg::lpbe_flags_t fl;
    logic [N-1:0]          off;
    logic [N-1:0]          mnr;

    logic [N-1:0] out_x_reg;
    logic [N-1:0] out_y_reg;
    logic         out_last_reg;
    logic         out_beyond_reg;

    always_comb
    begin
        fl  = d_flags_reg[N-1];
        // single-point line: divisor is zero, offset is zero
        off = fl.len_zero ? '0 : d_quo_reg[N-1];
        mnr = fl.min_neg ? d_min_start_reg[N-1] - off : d_min_start_reg[N-1] + off;
    end

    always_ff @(posedge clk)
    begin
        if (take[OUT_ST])
        begin
            if (fl.beyond)
            begin
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_x_reg    <= fl.x_major ? d_maj_reg[N-1] : mnr;
                out_y_reg    <= fl.x_major ? mnr : d_maj_reg[N-1];
                out_last_reg <= fl.last;
            end
            out_beyond_reg <= fl.beyond;
        end
    end

    assign pixel.valid      = vld_reg[OUT_ST];
    assign pixel.pixel_x    = out_x_reg;
    assign pixel.pixel_y    = out_y_reg;
    assign pixel.last_pixel = out_last_reg;
    assign pixel.beyond_end = out_beyond_reg;

endmodule

`default_nettype wire

/* sim/line_point_by_equation_tb.sv */
`default_nettype none

module line_point_by_equation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB          = 10;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int PIPE_DEPTH  = CB + 3;
    localparam int PER_PHASE   = 150;
    localparam int NUM_DIRECTED = 24;

    typedef struct packed {
        logic [CB-1:0] start_x;
        logic [CB-1:0] start_y;
        logic [CB-1:0] end_x;
        logic [CB-1:0] end_y;
        logic [CB-1:0] step_index;
    } line_req_t;

    typedef struct packed {
        logic [CB-1:0] pixel_x;
        logic [CB-1:0] pixel_y;
        logic          last_pixel;
        logic          beyond_end;
    } pixel_t;

    typedef struct packed {
        line_req_t req;
        logic      typed;  // want holds a hand-written result
        pixel_t    want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lpbe_line_if  #(.COORD_BITS(CB)) line_bus ();
    lpbe_pixel_if #(.COORD_BITS(CB)) pixel_bus ();

    line_point_by_equation #(.COORD_BITS(CB)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .line  (line_bus),
        .pixel (pixel_bus)
    );

    always #4 clk = ~clk;

    pixel_t pixels_due[$];
    int     error_count   = 0;
    int     lines_sent    = 0;
    int     pixels_seen   = 0;
    int     beyond_seen   = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     recv_hold     = 0;

    // endpoints x0 y0 x1 y1, step, typed flag, expected x y last beyond
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{10'd0,    10'd0,    10'd0,    10'd0,    10'd0},    1'b1, '{10'd0,    10'd0,    1'b1, 1'b0}},
        '{'{10'd0,    10'd0,    10'd0,    10'd0,    10'd1},    1'b1, '{10'd0,    10'd0,    1'b0, 1'b1}},
        '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd0},    1'b1, '{10'd1023, 10'd1023, 1'b1, 1'b0}},
        '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{10'd0,    10'd0,    1'b0, 1'b1}},
        '{'{10'd0,    10'd0,    10'd1023, 10'd0,    10'd1023}, 1'b1, '{10'd1023, 10'd0,    1'b1, 1'b0}},
        '{'{10'd0,    10'd0,    10'd1023, 10'd0,    10'd0},    1'b1, '{10'd0,    10'd0,    1'b0, 1'b0}},
        '{'{10'd0,    10'd0,    10'd1023, 10'd1023, 10'd1023}, 1'b1, '{10'd1023, 10'd1023, 1'b1, 1'b0}},
        '{'{10'd1023, 10'd1023, 10'd0,    10'd0,    10'd1023}, 1'b1, '{10'd0,    10'd0,    1'b1, 1'b0}},
        '{'{10'd1023, 10'd0,    10'd0,    10'd1023, 10'd1023}, 1'b1, '{10'd0,    10'd1023, 1'b1, 1'b0}},
        '{'{10'd0,    10'd0,    10'd0,    10'd1023, 10'd1023}, 1'b1, '{10'd0,    10'd1023, 1'b1, 1'b0}},
        '{'{10'd0,    10'd1023, 10'd0,    10'd0,    10'd1023}, 1'b1, '{10'd0,    10'd0,    1'b1, 1'b0}},
        '{'{10'd5,    10'd5,    10'd10,   10'd5,    10'd6},    1'b1, '{10'd0,    10'd0,    1'b0, 1'b1}},
        '{'{10'd1023, 10'd1023, 10'd0,    10'd1022, 10'd1023}, 1'b1, '{10'd0,    10'd1022, 1'b1, 1'b0}},
        // exact halves, both directions, both major axes
        '{'{10'd0,    10'd0,    10'd4,    10'd1,    10'd2},    1'b0, '0},
        '{'{10'd0,    10'd10,   10'd4,    10'd9,    10'd2},    1'b0, '0},
        '{'{10'd10,   10'd0,    10'd9,    10'd4,    10'd2},    1'b0, '0},
        '{'{10'd10,   10'd20,   10'd11,   10'd16,   10'd2},    1'b0, '0},
        '{'{10'd100,  10'd200,  10'd900,  10'd650,  10'd400},  1'b0, '0},
        '{'{10'd900,  10'd650,  10'd100,  10'd200,  10'd400},  1'b0, '0},
        '{'{10'd512,  10'd0,    10'd511,  10'd1023, 10'd700},  1'b0, '0},
        '{'{10'd0,    10'd0,    10'd1023, 10'd1022, 10'd512},  1'b0, '0},
        '{'{10'd1023, 10'd0,    10'd0,    10'd1022, 10'd511},  1'b0, '0},
        '{'{10'd0,    10'd0,    10'd1023, 10'd1023, 10'd512},  1'b0, '0},
        '{'{10'd341,  10'd682,  10'd682,  10'd341,  10'd1000}, 1'b0, '0}
    };

    function automatic pixel_t predict_pixel(input line_req_t r);
        pixel_t p;
        int     dx, dy, adx, ady, len, dmin, off, step, maj, mnr, maj_start, min_start;
        bit     x_major, maj_neg, min_neg;
        p    = '0;
        step = int'(r.step_index);
        dx   = int'(r.end_x) - int'(r.start_x);
        dy   = int'(r.end_y) - int'(r.start_y);
        adx  = (dx < 0) ? -dx : dx;
        ady  = (dy < 0) ? -dy : dy;
        x_major   = (ady <= adx);
        len       = x_major ? adx : ady;
        dmin      = x_major ? ady : adx;
        maj_neg   = x_major ? (dx < 0) : (dy < 0);
        min_neg   = x_major ? (dy < 0) : (dx < 0);
        maj_start = x_major ? int'(r.start_x) : int'(r.start_y);
        min_start = x_major ? int'(r.start_y) : int'(r.start_x);
        if (step > len)
        begin
            p.beyond_end = 1'b1;
            return p;
        end
        off = (len != 0) ? (2 * step * dmin + len) / (2 * len) : 0;
        maj = maj_neg ? maj_start - step : maj_start + step;
        mnr = min_neg ? min_start - off : min_start + off;
        p.pixel_x    = CB'(x_major ? maj : mnr);
        p.pixel_y    = CB'(x_major ? mnr : maj);
        p.last_pixel = (step == len);
        return p;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Mostly real lines with steps on them; some flat, steep, diagonal, tiny
    // or single-point lines, and a share of steps past the end.
    function automatic line_req_t random_line();
        line_req_t r;
        int        sx, sy, ex, ey, d, len, pick, step;
        bit        neg_x, neg_y;
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
        pick = $urandom_range(0, 9);
        case (pick)
            0:
            begin
                ex = sx;
                ey = sy;
            end
            1: ex = sx;
            2: ey = sy;
            3:
            begin
                neg_x = 1'($urandom_range(0, 1));
                neg_y = 1'($urandom_range(0, 1));
                d = neg_x ? sx : COORD_MAX - sx;
                if ((neg_y ? sy : COORD_MAX - sy) < d)
                    d = neg_y ? sy : COORD_MAX - sy;
                d  = $urandom_range(0, d);
                ex = neg_x ? sx - d : sx + d;
                ey = neg_y ? sy - d : sy + d;
            end
            4, 5:
            begin
                ex = clamp_coord(sx + int'($urandom_range(0, 16)) - 8);
                ey = clamp_coord(sy + int'($urandom_range(0, 16)) - 8);
            end
            default: ;
        endcase
        len = (ex > sx) ? ex - sx : sx - ex;
        d   = (ey > sy) ? ey - sy : sy - ey;
        if (d > len)
            len = d;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            step = len;
        else if (pick == 1 && len < COORD_MAX)
            step = $urandom_range(len + 1, COORD_MAX);
        else if (pick == 2)
            step = $urandom_range(0, COORD_MAX);
        else
            step = $urandom_range(0, len);
        r.start_x    = CB'(sx);
        r.start_y    = CB'(sy);
        r.end_x      = CB'(ex);
        r.end_y      = CB'(ey);
        r.step_index = CB'(step);
        return r;
    endfunction

    // valid stays high across back-to-back transfers; it drops only in a gap
    task automatic send_line(input line_req_t r, input bit typed, input pixel_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            line_bus.valid <= 1'b0;
            @(posedge clk);
        end
        line_bus.valid      <= 1'b1;
        line_bus.start_x    <= r.start_x;
        line_bus.start_y    <= r.start_y;
        line_bus.end_x      <= r.end_x;
        line_bus.end_y      <= r.end_y;
        line_bus.step_index <= r.step_index;
        @(posedge clk);
        while (!line_bus.ready)
            @(posedge clk);
        pixels_due.push_back(typed ? want : predict_pixel(r));
        lines_sent++;
    endtask

    // called right at an accepting edge: stop offering, then wait for results
    task automatic drain_pixels();
        line_bus.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
    endtask

    // receiver: check each pixel transfer, then pick ready for the next cycle
    initial
    begin
        pixel_t got, want;
        pixel_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_bus.valid && pixel_bus.ready)
            begin
                got = '{pixel_bus.pixel_x, pixel_bus.pixel_y,
                        pixel_bus.last_pixel, pixel_bus.beyond_end};
                pixels_seen++;
                if (got.beyond_end)
                    beyond_seen++;
                if (pixels_due.size() == 0)
                begin
                    $error("pixel transfer with no request pending");
                    error_count++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got.pixel_x !== want.pixel_x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
                        error_count++;
                    end
                    if (got.pixel_y !== want.pixel_y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
                        error_count++;
                    end
                    if (got.last_pixel !== want.last_pixel)
                    begin
                        $error("last_pixel: expected %0d, got %0d",
                               want.last_pixel, got.last_pixel);
                        error_count++;
                    end
                    if (got.beyond_end !== want.beyond_end)
                    begin
                        $error("beyond_end: expected %0d, got %0d",
                               want.beyond_end, got.beyond_end);
                        error_count++;
                    end
                end
            end
            if (recv_hold > 0)
            begin
                pixel_bus.ready <= 1'b0;
                recv_hold--;
            end
            else
            begin
                pixel_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d pixels still pending", pixels_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int send_pcts [4];
        int recv_pcts [4];
        send_pcts = '{0, 66, 0, 7};
        recv_pcts = '{0, 0, 66, 7};
        line_bus.valid      = 1'b0;
        line_bus.start_x    = '0;
        line_bus.start_y    = '0;
        line_bus.end_x      = '0;
        line_bus.end_y      = '0;
        line_bus.step_index = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_line(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            // sender pauses here until the pipeline has emptied
            drain_pixels();
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            // long output stall while requests keep coming: fills every stage
            if (ph == 0)
                recv_hold = 4 * PIPE_DEPTH + 60;
            for (int n = 0; n < PER_PHASE; n++)
                send_line(random_line(), 1'b0, '0);
        end

        drain_pixels();
        repeat (PIPE_DEPTH + 20) @(posedge clk);

        $display("ran %0d line requests (%0d directed), %0d pixels checked, %0d past the end",
                 lines_sent, NUM_DIRECTED, pixels_seen, beyond_seen);
        $display("idle patterns: none, sender gaps, receiver stalls, both light; one long stall");
        if (error_count == 0 && pixels_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/lpbe_pkg.sv
rtl/core/lpbe_line_if.sv
rtl/core/lpbe_pixel_if.sv
rtl/core/line_point_by_equation.sv
sim/line_point_by_equation_tb.sv
